// ----- rtl/pvc_pkg.sv -----
// Package for the peak-tracked viewport controller.
// Sequencer states and fixed-point constants; no dependencies.
package pvc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP_X,
    ST_DIV_X,
    ST_PREP_Y,
    ST_DIV_Y,
    ST_UPDATE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_FIN,
    ST_EMIT
  } seq_state_t;

  typedef enum logic [2:0] {
    REG_MAP_COLUMNS   = 3'd0,
    REG_MAP_ROWS      = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_IMAGE_HEIGHT  = 3'd3,
    REG_WINDOW_WIDTH  = 3'd4,
    REG_WINDOW_HEIGHT = 3'd5,
    REG_DIRECT_FOLLOW = 3'd6
  } cfg_reg_t;

  localparam logic        OP_CELL      = 1'b0;
  localparam logic        OP_NO_MAP    = 1'b1;
  localparam logic [1:0]  LEARN_CLEAR  = 2'd1;
  localparam logic [1:0]  LEARN_ACTIVE = 2'd2;

  localparam logic [16:0] HALF_Q16    = 17'd32768;
  localparam logic [16:0] NEAR_Q16    = 17'd3277;
  localparam logic signed [15:0] PEAK_HALF = 16'sd2048;
  localparam logic [23:0] PHASE_LIMIT = 24'd5120;
  localparam logic [23:0] PHASE_MAX   = 24'hFFFFFF;
  localparam logic [31:0] LEARN_START = 32'd6400;
  localparam logic [31:0] LEARN_END   = 32'd83200;
  localparam int unsigned DEF_COLS    = 180;
  localparam int unsigned DEF_ROWS    = 120;

endpackage

// ----- rtl/pvc_div.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
// Used for the centre fractions; depends on nothing.
module pvc_div #(
  parameter int NW = 28,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  numsh;
  logic [DW-1:0]  rem;
  logic [DW-1:0]  dreg;
  logic [CNW-1:0] cnt;
  logic [DW:0]    trial;
  logic           ge;

  assign trial = {rem, numsh[NW-1]};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt   <= CNW'(NW);
        numsh <= num;
        dreg  <= den;
        rem   <= '0;
      end else if (cnt != '0) begin
        rem   <= ge ? DW'(trial - {1'b0, dreg}) : trial[DW-1:0];
        quot  <= {quot[NW-2:0], ge};
        numsh <= {numsh[NW-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
        if (cnt == CNW'(1)) done <= 1'b1;
      end
    end
  end
endmodule

// ----- rtl/peak_tracked_viewport_controller.sv -----
// Peak-tracked viewport controller: map peak search and frame-end sequencer.
// Depends on pvc_pkg and pvc_div.
// Map cells: one word per cycle while in_stall is low. A frame end (last cell
// or no-map word) runs the bit-serial divider twice, then the update and
// multiply states, with input stalled. Result word follows the frame end.
// Reset is synchronous: config and tracking registers take defaults, saccade state idle.
module peak_tracked_viewport_controller
  import pvc_pkg::*;
#(
  parameter int MAP_MAX   = 1024,
  parameter int IMAGE_MAX = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [15:0] cell_value,
  input  logic               last_cell,
  input  logic [15:0]        step_time,
  input  logic [1:0]         learn_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [13:0] window_left,
  output logic signed [13:0] window_top,
  output logic               blank,
  output logic               done_signal,
  output logic [9:0]         kernel_column,
  output logic [9:0]         kernel_row,
  output logic               kernel_valid,
  output logic               size_error
);
  localparam int CW  = $clog2(MAP_MAX);
  localparam int KW  = (CW + 1 > 8) ? CW + 1 : 8;
  localparam int IW  = $clog2(IMAGE_MAX + 1);
  localparam int NW  = CW + 18;
  localparam int DW  = CW + 2;
  localparam int PW  = 17 + IW;

  function automatic logic [KW-1:0] clamp_map(input logic [10:0] v);
    if (v == '0) return KW'(1);
    if (32'(v) > 32'(MAP_MAX)) return KW'(MAP_MAX);
    return KW'(v);
  endfunction

  function automatic logic [IW-1:0] clamp_img(input logic [12:0] v);
    if (v == '0) return IW'(1);
    if (32'(v) > 32'(IMAGE_MAX)) return IW'(IMAGE_MAX);
    return IW'(v);
  endfunction

  function automatic logic [CW-1:0] mid_of(input logic [KW-1:0] n);
    logic [KW:0] m;
    m = ({1'b0, n} + 1'b1) >> 1;
    if (m > {1'b0, n} - 1'b1) return CW'(n - 1'b1);
    return CW'(m);
  endfunction

  // configuration
  logic [10:0] map_columns, map_rows;
  logic [12:0] image_width, image_height, window_width, window_height;
  logic        direct_follow;

  logic [KW-1:0] cols, rows;
  logic [IW-1:0] iw, ih;
  logic          err_now;

  assign cols = clamp_map(map_columns);
  assign rows = clamp_map(map_rows);
  assign iw   = clamp_img(image_width);
  assign ih   = clamp_img(image_height);
  assign err_now = (16'(window_width) > 16'(iw)) || (16'(window_height) > 16'(ih));

  // scan and peak
  logic signed [15:0] best_value;
  logic [CW-1:0] best_column, best_row, scan_column, scan_row;

  // persistent tracking state
  logic [16:0]   held_x, held_y;
  logic          moving, settling, done_level, kern_valid;
  logic [23:0]   phase_time;
  logic [31:0]   learn_time;
  logic [CW-1:0] kern_col, kern_row;
  logic [KW-1:0] kern_cols, kern_rows;

  // frame-end working registers
  seq_state_t         state, state_next;
  logic               f_op, f_err, f_blank;
  logic [1:0]         f_learn;
  logic [15:0]        f_dt;
  logic signed [15:0] f_best;
  logic [CW-1:0]      f_col, f_row, bc, br;
  logic [16:0]        cx, cy;
  logic signed [13:0] off_l, off_t, left_r, top_r;
  logic [PW-1:0]      prod;

  assign bc = (KW'(f_col) < cols) ? f_col : CW'(cols - 1'b1);
  assign br = (KW'(f_row) < rows) ? f_row : CW'(rows - 1'b1);

  // divider
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quot;
  logic [DW-1:0] div_den;

  pvc_div #(.NW(NW), .DW(DW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign in_stall = rst || (state != ST_IDLE);

  logic accept, better, frame_end;
  logic [CW-1:0] col_fin, row_fin;
  assign accept    = in_valid && !in_stall;
  assign better    = (opcode == OP_CELL) && (cell_value > best_value);
  assign frame_end = (opcode == OP_NO_MAP) || last_cell;
  assign col_fin   = better ? scan_column : best_column;
  assign row_fin   = better ? scan_row : best_row;

  // frame update
  logic          u_mv, u_st, u_dn, u_kv, u_bl, u_start, u_in_win;
  logic [16:0]   u_hx, u_hy, dx, dy;
  logic [23:0]   u_ph;
  logic [24:0]   ph_sum;
  logic [31:0]   u_lt, lt_rel;
  logic [32:0]   lt_sum;
  logic [CW-1:0] u_kc, u_kr;
  logic [KW-1:0] u_kcs, u_krs;
  logic signed [13:0] u_ol, u_ot, hvw, hvh, qvh;
  logic [6:0]    slot_x;
  logic [14:0]   slot_m;
  logic [3:0]    s;

  assign hvw = 14'(window_width >> 1);
  assign hvh = 14'(window_height >> 1);
  assign qvh = 14'(window_height >> 2);

  always_comb begin
    u_mv = moving;  u_st = settling; u_dn = done_level; u_kv = kern_valid;
    u_hx = held_x;  u_hy = held_y;   u_ph = phase_time; u_lt = learn_time;
    u_kc = kern_col; u_kr = kern_row; u_kcs = kern_cols; u_krs = kern_rows;
    u_bl = 1'b0; u_ol = '0; u_ot = '0; u_start = 1'b0;
    dx = '0; dy = '0; ph_sum = '0; lt_sum = '0; lt_rel = '0;
    slot_x = '0; slot_m = '0; s = '0; u_in_win = 1'b0;
    if (!f_err) begin
      if (f_op == OP_NO_MAP) begin
        u_hx = HALF_Q16; u_hy = HALF_Q16; u_mv = 1'b0; u_st = 1'b0;
        u_ph = '0; u_lt = '0; u_kv = 1'b0; u_kc = '0; u_kr = '0;
        u_kcs = KW'(DEF_COLS); u_krs = KW'(DEF_ROWS); u_dn = 1'b0; u_bl = 1'b1;
      end else begin
        if (kern_cols != cols || kern_rows != rows) begin
          u_mv = 1'b0; u_st = 1'b0; u_hx = HALF_Q16; u_hy = HALF_Q16; u_ph = '0;
          u_kcs = cols; u_krs = rows; u_kc = mid_of(cols); u_kr = mid_of(rows);
          u_kv = 1'b1;
        end
        if (direct_follow) begin
          if (f_best < PEAK_HALF) begin
            u_bl = 1'b1;
          end else begin
            u_kc = bc; u_kr = br; u_kv = 1'b1;
          end
        end else begin
          dx = (u_hx > cx) ? u_hx - cx : cx - u_hx;
          dy = (u_hy > cy) ? u_hy - cy : cy - u_hy;
          u_start = !u_mv && !u_st && (dx > NEAR_Q16 || dy > NEAR_Q16) &&
                    (f_best > PEAK_HALF);
          if (u_start) begin
            u_hx = cx; u_hy = cy; u_mv = 1'b1; u_st = 1'b0; u_ph = '0;
            u_kc = bc; u_kr = br; u_kv = 1'b1;
          end
          ph_sum = {1'b0, u_ph} + 25'(f_dt);
          if (u_mv) begin
            u_dn = 1'b0; u_bl = 1'b1;
            if (u_ph > PHASE_LIMIT) begin
              u_mv = 1'b0; u_st = 1'b1; u_dn = 1'b1; u_ph = '0;
            end else begin
              u_ph = ph_sum[24] ? PHASE_MAX : ph_sum[23:0];
            end
          end else begin
            if (u_st) begin
              if (u_ph > PHASE_LIMIT) begin
                u_st = 1'b0; u_dn = 1'b0; u_ph = '0;
              end else begin
                u_ph = ph_sum[24] ? PHASE_MAX : ph_sum[23:0];
              end
            end
            if (f_learn == LEARN_ACTIVE) begin
              lt_sum = {1'b0, u_lt} + 33'(f_dt);
              u_lt = lt_sum[32] ? 32'hFFFFFFFF : lt_sum[31:0];
              u_in_win = (u_lt >= LEARN_START) && (u_lt < LEARN_END);
              if (u_in_win) begin
                // slot of 5120: >> 10 then divide by five
                lt_rel = u_lt - LEARN_START;
                slot_x = 7'(lt_rel >> 10);
                slot_m = 15'(slot_x) * 15'd205;
                s = 4'(slot_m >> 10);
                if (s <= 4'd2) u_ot = hvh;
                else if (s <= 4'd5) u_ot = qvh;
                else if (s >= 4'd9 && s <= 4'd11) u_ot = -qvh;
                else if (s >= 4'd12) u_ot = -hvh;
                case (s)
                  4'd0, 4'd3, 4'd6, 4'd9, 4'd12:  u_ol = hvw;
                  4'd2, 4'd5, 4'd8, 4'd11, 4'd14: u_ol = -hvw;
                  default: u_ol = '0;
                endcase
              end
            end else if (f_learn == LEARN_CLEAR) begin
              u_lt = '0;
            end
          end
        end
      end
    end
  end

  // shared multiplier for the pixel positions
  logic [16:0]    mul_a;
  logic [IW-1:0]  mul_b;
  logic [PW:0]    rnd;
  logic signed [13:0] pix;

  always_comb begin
    mul_a = (state == ST_MUL_X) ? (direct_follow ? cx : held_x)
                                : (direct_follow ? cy : held_y);
    mul_b = (state == ST_MUL_X) ? iw : ih;
  end
  assign rnd = {1'b0, prod} + (PW+1)'(32768);
  assign pix = 14'(rnd >> 16);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    case (state)
      ST_IDLE:   if (accept && frame_end) state_next = ST_PREP_X;
      ST_PREP_X: begin
        div_start  = 1'b1;
        div_num    = (NW'(bc) << 17) + NW'(cols);
        div_den    = DW'({cols, 1'b0});
        state_next = ST_DIV_X;
      end
      ST_DIV_X:  if (div_done) state_next = ST_PREP_Y;
      ST_PREP_Y: begin
        div_start  = 1'b1;
        div_num    = (NW'(br) << 17) + NW'(rows);
        div_den    = DW'({rows, 1'b0});
        state_next = ST_DIV_Y;
      end
      ST_DIV_Y:  if (div_done) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_MUL_X;
      ST_MUL_X:  state_next = ST_MUL_Y;
      ST_MUL_Y:  state_next = ST_FIN;
      ST_FIN:    state_next = ST_EMIT;
      ST_EMIT:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_columns   <= 11'(DEF_COLS);
      map_rows      <= 11'(DEF_ROWS);
      image_width   <= 13'd640;
      image_height  <= 13'd480;
      window_width  <= 13'd10;
      window_height <= 13'd10;
      direct_follow <= 1'b0;
      best_value    <= 16'sh8000;
      best_column   <= '0;
      best_row      <= '0;
      scan_column   <= '0;
      scan_row      <= '0;
      held_x        <= HALF_Q16;
      held_y        <= HALF_Q16;
      moving        <= 1'b0;
      settling      <= 1'b0;
      phase_time    <= '0;
      learn_time    <= '0;
      done_level    <= 1'b0;
      kern_cols     <= clamp_map(11'(DEF_COLS));
      kern_rows     <= clamp_map(11'(DEF_ROWS));
      kern_col      <= mid_of(clamp_map(11'(DEF_COLS)));
      kern_row      <= mid_of(clamp_map(11'(DEF_ROWS)));
      kern_valid    <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_EMIT) out_valid <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          REG_MAP_COLUMNS, REG_MAP_ROWS: begin
            if (cfg_index == REG_MAP_COLUMNS) map_columns <= cfg_data[10:0];
            else                              map_rows    <= cfg_data[10:0];
            best_value  <= 16'sh8000;
            best_column <= '0;
            best_row    <= '0;
            scan_column <= '0;
            scan_row    <= '0;
          end
          REG_IMAGE_WIDTH:   image_width   <= cfg_data;
          REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
          REG_WINDOW_WIDTH:  window_width  <= cfg_data;
          REG_WINDOW_HEIGHT: window_height <= cfg_data;
          REG_DIRECT_FOLLOW: direct_follow <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: if (accept) begin
          if (frame_end) begin
            f_op        <= opcode;
            f_err       <= err_now;
            f_learn     <= learn_mode;
            f_dt        <= step_time;
            f_best      <= better ? cell_value : best_value;
            f_col       <= col_fin;
            f_row       <= row_fin;
            best_value  <= 16'sh8000;
            best_column <= '0;
            best_row    <= '0;
            scan_column <= '0;
            scan_row    <= '0;
          end else begin
            if (better) begin
              best_value  <= cell_value;
              best_column <= scan_column;
              best_row    <= scan_row;
            end
            if (KW'(scan_column) + 1'b1 >= cols) begin
              scan_column <= '0;
              scan_row    <= (KW'(scan_row) + 1'b1 >= rows) ? '0 : scan_row + 1'b1;
            end else begin
              scan_column <= scan_column + 1'b1;
            end
          end
        end
        ST_DIV_X: if (div_done) cx <= div_quot[16:0];
        ST_DIV_Y: if (div_done) cy <= div_quot[16:0];
        ST_UPDATE: begin
          moving     <= u_mv;
          settling   <= u_st;
          done_level <= u_dn;
          kern_valid <= u_kv;
          held_x     <= u_hx;
          held_y     <= u_hy;
          phase_time <= u_ph;
          learn_time <= u_lt;
          kern_col   <= u_kc;
          kern_row   <= u_kr;
          kern_cols  <= u_kcs;
          kern_rows  <= u_krs;
          f_blank    <= u_bl;
          off_l      <= u_ol;
          off_t      <= u_ot;
        end
        ST_MUL_X: prod <= PW'(mul_a) * PW'(mul_b);
        ST_MUL_Y: begin
          left_r <= pix + off_l;
          prod   <= PW'(mul_a) * PW'(mul_b);
        end
        ST_FIN: top_r <= pix + off_t;
        ST_EMIT: if (!out_valid || !out_stall) begin
          out_valid     <= 1'b1;
          window_left   <= (f_blank || f_err) ? '0 : left_r;
          window_top    <= (f_blank || f_err) ? '0 : top_r;
          blank         <= f_blank;
          done_signal   <= done_level;
          kernel_column <= kern_valid ? 10'(kern_col) : '0;
          kernel_row    <= kern_valid ? 10'(kern_row) : '0;
          kernel_valid  <= kern_valid;
          size_error    <= f_err;
        end
        default: ;
      endcase
    end
  end
endmodule
